/* hdl/plid_pkg.sv */
// shared request and status codes and the result record for the positional list
package plid_pkg;

  // request codes
  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_DELETE = 3'd2;
  localparam logic [2:0] REQ_FIND   = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  // status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_RANGE     = 3'd2;
  localparam logic [2:0] STAT_EMPTY     = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  // one finished result, handed from the controller to the output stage
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [6:0]  found_position;
    logic [6:0]  list_length;
    logic        is_empty;
  } plid_result_t;

endpackage

/* hdl/positional_list_insert_delete.sv */
// top level of the positional list: controller, element store and output register
//
//  channel  ports                                   direction
//  -------  --------------------------------------  ---------
//  in       in_valid/in_ready, req_type, position,  input
//           value
//  out      out_valid/out_ready, status, read_value, output
//           found_position, list_length, is_empty
//
// clear and rejected requests finish without a walk; read, insert, delete and find
// walk the store through the single read port, an insert or delete shifting the
// elements behind its position and a find stopping at the first match.
// rst_n clears the length and the controls; the store itself is not cleared.
// a result waits in the output register while the next request is taken in;
// a stalled output holds the controller only once its next result is ready.
module positional_list_insert_delete #(
  parameter int LIST_DEPTH = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [6:0]  out_found_position,
  output logic [6:0]  out_list_length,
  output logic        out_is_empty
);

  import plid_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic                  res_valid, res_ready;
  plid_result_t          res;
  logic                  ram_re, ram_we;
  logic [AW-1:0]         ram_raddr, ram_waddr;
  logic [DATA_WIDTH-1:0] ram_rdata, ram_wdata;
  logic                  out_valid_r;
  plid_result_t          out_r;

  // sequencer
  plid_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_position (in_position),
    .in_value    (in_value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  // element store
  plid_ram #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register, loads whenever it is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_read_value     = out_r.read_value;
  assign out_found_position = out_r.found_position;
  assign out_list_length    = out_r.list_length;
  assign out_is_empty       = out_r.is_empty;

  // one request at a time: the controller is busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while controller busy");

  // a result moved into the output register is shown next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid)
    else $error("result lost on the way to the output register");

  // a failed search never reports a position
  a_not_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_NOT_FOUND || out_status == STAT_EMPTY)
      |-> out_found_position == 7'd0)
    else $error("position reported with a failed search");

  // empty flag agrees with the reported length
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (LIST_DEPTH < 128) |-> out_is_empty == (out_list_length == 7'd0))
    else $error("empty flag disagrees with length");

endmodule

/* hdl/plid_ram.sv */
// element store: one write port, one read port with registered read data
module plid_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/plid_ctrl.sv */
// request sequencer: checks, streams reads and shifted writebacks, builds the result
module plid_ctrl #(
  parameter int LIST_DEPTH = 64,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 6,
  parameter int CW         = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_req_type,
  input  logic [6:0]             in_position,
  input  logic [31:0]            in_value,
  output logic                   res_valid,
  input  logic                   res_ready,
  output plid_pkg::plid_result_t res,
  output logic                   ram_re,
  output logic [AW-1:0]          ram_raddr,
  input  logic [DATA_WIDTH-1:0]  ram_rdata,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic [DATA_WIDTH-1:0]  ram_wdata
);

  import plid_pkg::*;

  localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [2:0]            req_r, req_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]         rptr_r, rptr_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         paddr_r, paddr_nxt;
  logic                  first_r, first_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  plid_result_t          res_r, res_nxt;
  logic                  go_done;
  logic [CMPW-1:0]       cnt_x, pos_x;
  logic                  pos_bad, ins_bad;

  // widened operands for the range checks
  assign cnt_x   = CMPW'(count_r);
  assign pos_x   = CMPW'(in_position);
  assign pos_bad = (pos_x == '0) || (pos_x > cnt_x);
  assign ins_bad = (pos_x == '0) || (pos_x > cnt_x + CMPW'(1));

  // next state and memory access
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    rptr_nxt  = rptr_r;
    left_nxt  = left_r;
    pend_nxt  = 1'b0;
    paddr_nxt = paddr_r;
    first_nxt = first_r;
    count_nxt = count_r;
    res_nxt   = res_r;
    go_done   = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rptr_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = val_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          pos_nxt   = AW'(pos_x - CMPW'(1));
          val_nxt   = DATA_WIDTH'(in_value);
          first_nxt = 1'b1;
          res_nxt   = '0;
          res_nxt.status = STAT_OK;
          case (in_req_type)
            REQ_READ, REQ_DELETE: begin
              if (cnt_x == '0) begin
                res_nxt.status = STAT_EMPTY;
                go_done = 1'b1;
              end else if (pos_bad) begin
                res_nxt.status = STAT_RANGE;
                go_done = 1'b1;
              end else begin
                rptr_nxt  = AW'(pos_x - CMPW'(1));
                left_nxt  = (in_req_type == REQ_READ) ? CW'(1)
                                                      : CW'(cnt_x - pos_x + CMPW'(1));
                state_nxt = ST_WALK;
              end
            end
            REQ_INSERT: begin
              if (cnt_x >= CMPW'(LIST_DEPTH)) begin
                res_nxt.status = STAT_FULL;
                go_done = 1'b1;
              end else if (ins_bad) begin
                res_nxt.status = STAT_RANGE;
                go_done = 1'b1;
              end else begin
                // walk from the tail down to the insert point
                rptr_nxt  = AW'(cnt_x - CMPW'(1));
                left_nxt  = CW'(cnt_x - pos_x + CMPW'(1));
                state_nxt = ST_WALK;
              end
            end
            REQ_FIND: begin
              if (cnt_x == '0) begin
                res_nxt.status = STAT_EMPTY;
                go_done = 1'b1;
              end else begin
                rptr_nxt  = '0;
                left_nxt  = count_r;
                state_nxt = ST_WALK;
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
              go_done   = 1'b1;
            end
            default: begin
              go_done = 1'b1;
            end
          endcase
        end
      end

      ST_WALK: begin
        // issue the next read of the walk
        if (left_r != '0) begin
          ram_re    = 1'b1;
          rptr_nxt  = (req_r == REQ_INSERT) ? rptr_r - AW'(1) : rptr_r + AW'(1);
          left_nxt  = left_r - CW'(1);
          pend_nxt  = 1'b1;
          paddr_nxt = rptr_r;
        end
        if (pend_r) begin
          // data from the previous read is back
          first_nxt = 1'b0;
          case (req_r)
            REQ_READ: begin
              res_nxt.read_value = 32'(ram_rdata);
            end
            REQ_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = paddr_r + AW'(1);
              ram_wdata = ram_rdata;
            end
            REQ_DELETE: begin
              if (first_r) begin
                res_nxt.read_value = 32'(ram_rdata);
              end else begin
                ram_we    = 1'b1;
                ram_waddr = paddr_r - AW'(1);
                ram_wdata = ram_rdata;
              end
            end
            REQ_FIND: begin
              if (ram_rdata == val_r) begin
                res_nxt.found_position = 7'({1'b0, paddr_r} + 1'b1);
                go_done = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if (left_r == '0) begin
          // walk finished: new element written for an insert, length update, not found for a find
          case (req_r)
            REQ_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = pos_r;
              ram_wdata = val_r;
              count_nxt = count_r + CW'(1);
            end
            REQ_DELETE: begin
              count_nxt = count_r - CW'(1);
            end
            REQ_FIND: begin
              res_nxt.status = STAT_NOT_FOUND;
            end
            default: begin
            end
          endcase
          go_done = 1'b1;
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // length and empty flag reflect the list after the request
    if (go_done) begin
      state_nxt           = ST_DONE;
      res_nxt.list_length = 7'(count_nxt);
      res_nxt.is_empty    = (count_nxt == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // request and walk payload registers
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    rptr_r  <= rptr_nxt;
    left_r  <= left_nxt;
    paddr_r <= paddr_nxt;
    first_r <= first_nxt;
    res_r   <= res_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

endmodule
